// ----- sv/odf_pkg.sv -----
// Shared types and constants for the over-current filter and detector.
// Holds the fixed-point constants, register indexes and the stage strobes.
// No dependencies.
`default_nettype none

package odf_pkg;

    localparam int N_SAMPLES   = 5;
    localparam int CUR_BITS    = 12;
    localparam int LIMIT_BITS  = 10;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Filter gain 0.02 as GAIN_Q / 2^GAIN_SHIFT, mA scale as SCALE_Q / 2^SCALE_SHIFT.
    localparam int GAIN_Q      = 1311;
    localparam int GAIN_BITS   = 12;
    localparam int GAIN_SHIFT  = 16;
    localparam int SCALE_Q     = 33130;
    localparam int SCALE_SHIFT = 16;
    localparam int OFFSET_MA   = 200;

    localparam int CUR_MAX     = 2 ** (CUR_BITS - 1) - 1;
    localparam int CUR_MIN     = -(2 ** (CUR_BITS - 1));

    localparam logic [CUR_BITS-1:0]   MAX_CURRENT_RESET = 12'd1500;
    localparam logic [LIMIT_BITS-1:0] PERSIST_RESET     = 10'd50;

    // Register indexes, taken from paddr[2].
    localparam logic REG_MAX_CURRENT = 1'b0;
    localparam logic REG_PERSIST     = 1'b1;

    typedef struct packed {
        logic is_min;
        logic is_max;
    } odf_rank_t;

    typedef struct packed {
        logic sum_en;
        logic mean_en;
        logic mult_en;
        logic acc_en;
        logic scale_en;
        logic conv_en;
    } odf_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/odf_lane.sv -----
// One ranking lane: decides whether its own sample is the minimum or the maximum
// of the scan. Ties go to the lowest index. Depends on odf_pkg.
`default_nettype none

module odf_lane #(
    parameter int SAMPLE_BITS = 12,
    parameter int IDX         = 0
) (
    input  wire logic [SAMPLE_BITS-1:0] samples [odf_pkg::N_SAMPLES],
    output odf_pkg::odf_rank_t          rank
);
    import odf_pkg::*;

    always_comb
    begin
        rank.is_min = 1'b1;
        rank.is_max = 1'b1;
        for (int j = 0; j < N_SAMPLES; j++)
        begin
            if (j < IDX)
            begin
                if (!(samples[IDX] < samples[j]))
                    rank.is_min = 1'b0;
                if (!(samples[IDX] > samples[j]))
                    rank.is_max = 1'b0;
            end
            else if (j > IDX)
            begin
                if (samples[IDX] > samples[j])
                    rank.is_min = 1'b0;
                if (samples[IDX] < samples[j])
                    rank.is_max = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/odf_trim.sv -----
// Merging stage of the lanes: removes the minimum and maximum from the scan
// sum and divides the middle three by three. Depends on odf_pkg.
`default_nettype none

module odf_trim #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                   clk,
    input  wire logic [SAMPLE_BITS-1:0] samples [odf_pkg::N_SAMPLES],
    input  odf_pkg::odf_rank_t          ranks   [odf_pkg::N_SAMPLES],
    input  odf_pkg::odf_ctrl_t          ctrl,
    output logic      [SAMPLE_BITS-1:0] mean
);
    import odf_pkg::*;

    localparam int MID_W  = SAMPLE_BITS + 2;
    localparam int TOT_W  = SAMPLE_BITS + 3;
    // floor(x / 3) as (x * RECIP) >> DIV_K, exact for every x below 2^MID_W.
    localparam int DIV_K  = SAMPLE_BITS + 3;
    localparam logic [DIV_K-1:0] RECIP = DIV_K'((2 ** DIV_K) / 3 + 1);
    localparam int PROD_W = MID_W + DIV_K;

    logic [TOT_W-1:0]       total;
    logic [SAMPLE_BITS-1:0] min_val;
    logic [SAMPLE_BITS-1:0] max_val;
    logic [MID_W-1:0]       mid_reg;
    logic [MID_W-1:0]       mid_next;
    logic [PROD_W-1:0]      prod;
    logic [SAMPLE_BITS-1:0] mean_reg;

    always_comb
    begin
        total   = '0;
        min_val = '0;
        max_val = '0;
        for (int i = 0; i < N_SAMPLES; i++)
        begin
            total = total + TOT_W'(samples[i]);
            if (ranks[i].is_min)
                min_val = samples[i];
            if (ranks[i].is_max)
                max_val = samples[i];
        end
        mid_next = MID_W'(total - TOT_W'(min_val) - TOT_W'(max_val));
        prod     = PROD_W'(mid_reg) * PROD_W'(RECIP);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.sum_en)
            mid_reg <= mid_next;
        if (ctrl.mean_en)
            mean_reg <= prod[DIV_K +: SAMPLE_BITS];
    end

    assign mean = mean_reg;

endmodule

`default_nettype wire

// ----- sv/odf_filter.sv -----
// Low-pass filter on the trimmed mean and conversion of the filter value to mA.
// Holds the filter accumulator and the primed flag. Depends on odf_pkg.
`default_nettype none

module odf_filter #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  odf_pkg::odf_ctrl_t                ctrl,
    input  wire logic [SAMPLE_BITS-1:0]       mean,
    output logic      [odf_pkg::CUR_BITS-1:0] current
);
    import odf_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + FRAC_BITS;
    localparam int PW    = ACC_W + 1 + GAIN_BITS;
    localparam int TW    = ACC_W + SCALE_SHIFT;
    localparam int SH    = FRAC_BITS + SCALE_SHIFT;
    localparam int CW    = SAMPLE_BITS + CUR_BITS;

    localparam logic signed [PW-1:0] GAIN_S  = PW'(GAIN_Q);
    localparam logic signed [PW-1:0] ROUND_S = PW'(2 ** (GAIN_SHIFT - 1));
    localparam logic [ACC_W-1:0]     TOP     = {{SAMPLE_BITS{1'b1}}, {FRAC_BITS{1'b0}}};
    localparam logic [TW-1:0]        BASE    = TW'(OFFSET_MA) << SH;
    localparam logic signed [CW-1:0] SAT_HI  = CW'(CUR_MAX);
    localparam logic signed [CW-1:0] SAT_LO  = CW'(CUR_MIN);

    logic [ACC_W-1:0]       acc_reg;
    logic [ACC_W-1:0]       acc_next;
    logic                   primed_reg;
    logic signed [ACC_W:0]  d;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   delta;
    logic signed [PW-1:0]   sum_n;
    logic [TW-1:0]          t_reg;
    logic signed [TW:0]     diff;
    logic [TW:0]            mag;
    logic [SAMPLE_BITS-1:0] q;
    logic signed [SAMPLE_BITS:0] v;
    logic signed [CW-1:0]   v_ext;
    logic [CUR_BITS-1:0]    cur_reg;
    logic [CUR_BITS-1:0]    cur_next;

    always_comb
    begin
        d     = signed'({1'b0, mean, {FRAC_BITS{1'b0}}}) - signed'({1'b0, acc_reg});
        delta = (prod_reg + ROUND_S) >>> GAIN_SHIFT;
        sum_n = signed'({{(PW - ACC_W){1'b0}}, acc_reg}) + delta;
        if (sum_n[PW-1])
            acc_next = '0;
        else if (sum_n > signed'({{(PW - ACC_W){1'b0}}, TOP}))
            acc_next = TOP;
        else
            acc_next = sum_n[ACC_W-1:0];

        // Truncation toward zero: shift the magnitude, then restore the sign.
        diff  = signed'({1'b0, t_reg}) - signed'({1'b0, BASE});
        mag   = diff[TW] ? (TW + 1)'(-diff) : diff;
        q     = mag[SH +: SAMPLE_BITS];
        v     = diff[TW] ? -signed'({1'b0, q}) : signed'({1'b0, q});
        v_ext = CW'(v);
        if (v_ext > SAT_HI)
            cur_next = CUR_BITS'(CUR_MAX);
        else if (v_ext < SAT_LO)
            cur_next = CUR_BITS'(CUR_MIN);
        else
            cur_next = v_ext[CUR_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            primed_reg <= 1'b0;
        end
        else if (ctrl.acc_en)
        begin
            primed_reg <= 1'b1;
            if (primed_reg)
                acc_reg <= acc_next;
            else
                acc_reg <= {mean, {FRAC_BITS{1'b0}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mult_en)
            prod_reg <= PW'(d) * GAIN_S;
        if (ctrl.scale_en)
            t_reg <= TW'(acc_reg) * TW'(SCALE_Q);
        if (ctrl.conv_en)
            cur_reg <= cur_next;
    end

    assign current = cur_reg;

endmodule

`default_nettype wire

// ----- sv/overcurrent_filter_detector_core.sv -----
// Over-current filter and detector, top level: stream ports, register port,
// sequencer and persistence check. Depends on odf_pkg, odf_lane, odf_trim and odf_filter.
//
// Usage: each input word on s_tdata carries one scan of five converter samples.
// Five ranking lanes find the minimum and maximum, a merging stage averages the
// middle three, a first-order filter smooths the mean and the result is scaled
// to milliamps. One result word leaves on m_tdata/m_tuser for every input word.
// One scan occupies the sequencer while it passes the chain of registered stages
// (sum, divide, gain multiply, accumulate, scale multiply, convert, check), and
// a new word is taken only once the previous scan has left the last stage, which
// waits there while the output register still holds an undrained word.
// The output register holds a finished word while the receiver stalls; the next
// scan is accepted and processed meanwhile and waits in its last stage until the
// output register is free.
// Reset clears the filter (the first scan then loads it directly), the persistence
// counter and the fault bit, and sets the limit registers to 1500 mA and 50 scans.
// Registers must be written through the APB port while idle; the block does not check.
`default_nettype none

module overcurrent_filter_detector_core #(
    parameter int SAMPLE_BITS = 12,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // s_tdata: sample_a, sample_b, sample_c, sample_d, sample_e from bit 0 up
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [((5 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    // m_tdata: current_ma in bits 11:0, zeros above
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [15:0]                        m_tdata,
    // m_tuser: trip_pulse in bit 0, fault_latched in bit 1
    output logic [1:0]                         m_tuser,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [odf_pkg::APB_AW-1:0]    paddr,
    input  wire logic [odf_pkg::APB_DW-1:0]    pwdata,
    output logic      [odf_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);
    import odf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MEAN,
        ST_MULT,
        ST_ACC,
        ST_SCALE,
        ST_CONV,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [SAMPLE_BITS-1:0] samples_reg [N_SAMPLES];
    odf_rank_t              ranks [N_SAMPLES];
    odf_ctrl_t              ctrl;
    logic [SAMPLE_BITS-1:0] mean;
    logic [CUR_BITS-1:0]    current;
    logic [CUR_BITS-1:0]    max_current_reg;
    logic [LIMIT_BITS-1:0]  persist_reg;
    logic [LIMIT_BITS-1:0]  count_reg;
    logic                   fault_reg;
    logic                   trip_reg;
    logic [CUR_BITS-1:0]    cur_out_reg;
    logic                   m_tvalid_reg;
    logic                   in_take;
    logic                   out_free;
    logic                   over;
    logic                   cfg_write;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign over     = signed'(current) > signed'(max_current_reg);

    always_comb
    begin
        ctrl.sum_en   = (state_reg == ST_SUM);
        ctrl.mean_en  = (state_reg == ST_MEAN);
        ctrl.mult_en  = (state_reg == ST_MULT);
        ctrl.acc_en   = (state_reg == ST_ACC);
        ctrl.scale_en = (state_reg == ST_SCALE);
        ctrl.conv_en  = (state_reg == ST_CONV);
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < N_SAMPLES; i++)
                samples_reg[i] <= s_tdata[i * SAMPLE_BITS +: SAMPLE_BITS];
        end
    end

    for (genvar g = 0; g < N_SAMPLES; g++)
    begin : g_lane
        odf_lane #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .IDX        (g)
        ) u_lane (
            .samples(samples_reg),
            .rank   (ranks[g])
        );
    end

    odf_trim #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_trim (
        .clk    (clk),
        .samples(samples_reg),
        .ranks  (ranks),
        .ctrl   (ctrl),
        .mean   (mean)
    );

    odf_filter #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_filter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mean   (mean),
        .current(current)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            trip_reg     <= 1'b0;
            fault_reg    <= 1'b0;
            count_reg    <= '0;
            cur_out_reg  <= '0;
        end
        else
        begin
            // In the last stage a drained word is replaced by the new one below.
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                        state_reg <= ST_SUM;
                end
                ST_SUM:   state_reg <= ST_MEAN;
                ST_MEAN:  state_reg <= ST_MULT;
                ST_MULT:  state_reg <= ST_ACC;
                ST_ACC:   state_reg <= ST_SCALE;
                ST_SCALE: state_reg <= ST_CONV;
                ST_CONV:  state_reg <= ST_DONE;
                ST_DONE:
                begin
                    // The persistence check commits only once the word can be shown.
                    if (out_free)
                    begin
                        state_reg    <= ST_IDLE;
                        m_tvalid_reg <= 1'b1;
                        cur_out_reg  <= current;
                        if (over)
                        begin
                            if (count_reg >= persist_reg)
                            begin
                                count_reg <= '0;
                                fault_reg <= 1'b1;
                                trip_reg  <= 1'b1;
                            end
                            else
                            begin
                                count_reg <= count_reg + 1'b1;
                                trip_reg  <= 1'b0;
                            end
                        end
                        else
                        begin
                            count_reg <= '0;
                            trip_reg  <= 1'b0;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_current_reg <= MAX_CURRENT_RESET;
            persist_reg     <= PERSIST_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_MAX_CURRENT: max_current_reg <= pwdata[CUR_BITS-1:0];
                REG_PERSIST:     persist_reg     <= pwdata[LIMIT_BITS-1:0];
                default:         persist_reg     <= persist_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_MAX_CURRENT: prdata = APB_DW'(max_current_reg);
            REG_PERSIST:     prdata = APB_DW'(persist_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - CUR_BITS){1'b0}}, cur_out_reg};
    assign m_tuser  = {fault_reg, trip_reg};

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for overcurrent_filter_detector_core: stream and APB ports.
// A directed table and a long run of random scans are checked against a local filter model.
// Depends on odf_pkg and the core RTL only.
`default_nettype none

module tb_top;

    import odf_pkg::*;

    localparam int SMP_W       = 12;
    localparam int FRAC_W      = 16;
    localparam int ACC_TOP     = 4095 << FRAC_W;
    // Longest legal silence is the output hold-off plus a few pipeline
    // passes; the limit leaves several times that.
    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_OFF    = 300;
    localparam int SETTLE      = 20;
    localparam int SEG_ITEMS   = 270;
    localparam int N_SEGS      = 6;

    typedef enum logic {ROW_SCAN, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [CUR_BITS-1:0] cur;
        logic                trip;
        logic                fault;
    } reading_t;

    typedef struct packed {
        row_kind_t              kind;
        logic                   reg_sel;
        logic [11:0]            wval;
        logic [4:0][SMP_W-1:0]  smp;
        logic                   known;
        reading_t               want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata: sample_a, sample_b, sample_c, sample_d, sample_e from bit 0 up
    logic [63:0]          s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata: current_ma in bits 11:0, zeros above
    logic [15:0]          m_tdata;
    // m_tuser: trip_pulse in bit 0, fault_latched in bit 1
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // Filter model state and its copy of the limit registers.
    longint   acc_q;
    bit       acc_primed;
    int       over_cnt;
    bit       fault_seen;
    int       lim_ma;
    int       persist_lim;

    reading_t readings_due[$];
    int       fail_count;
    int       scans_in;
    int       scans_out;
    int       trips_seen;
    int       cfg_writes;
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_cycles;
    int       quiet_cycles;
    int       level;
    int       run_left;

    overcurrent_filter_detector_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        if (fail_count <= 100)
            $display("MISMATCH %s on result word %0d: got %0d, expected %0d",
                     what, scans_out, got, want);
    endtask

    // Trimmed mean of the scan, low-pass update, mA scaling and persistence check.
    function automatic reading_t predict_reading(input logic [4:0][SMP_W-1:0] smp);
        longint   sum;
        longint   lo;
        longint   hi;
        longint   mean;
        longint   diff;
        longint   nxt;
        longint   prod;
        longint   offs;
        longint   ma;
        reading_t r;
        sum = 0;
        lo  = smp[0];
        hi  = smp[0];
        for (int i = 0; i < N_SAMPLES; i++)
        begin
            sum += smp[i];
            if (smp[i] < lo)
                lo = smp[i];
            if (smp[i] > hi)
                hi = smp[i];
        end
        mean = (sum - lo - hi) / 3;
        if (!acc_primed)
        begin
            acc_q      = mean << FRAC_W;
            acc_primed = 1'b1;
        end
        else
        begin
            diff = (mean << FRAC_W) - acc_q;
            // Arithmetic shift floors, which is what the rounding step wants.
            nxt  = acc_q + ((diff * GAIN_Q + (longint'(1) << (GAIN_SHIFT - 1))) >>> GAIN_SHIFT);
            if (nxt < 0)
                nxt = 0;
            if (nxt > ACC_TOP)
                nxt = ACC_TOP;
            acc_q = nxt;
        end
        prod = acc_q * SCALE_Q;
        offs = longint'(OFFSET_MA) << (FRAC_W + SCALE_SHIFT);
        if (prod >= offs)
            ma = (prod - offs) >> (FRAC_W + SCALE_SHIFT);
        else
            ma = -((offs - prod) >> (FRAC_W + SCALE_SHIFT));
        if (ma > CUR_MAX)
            ma = CUR_MAX;
        if (ma < CUR_MIN)
            ma = CUR_MIN;
        r.cur  = ma[CUR_BITS-1:0];
        r.trip = 1'b0;
        if (ma > lim_ma)
        begin
            if (over_cnt >= persist_lim)
            begin
                over_cnt   = 0;
                fault_seen = 1'b1;
                r.trip     = 1'b1;
            end
            else
                over_cnt++;
        end
        else
            over_cnt = 0;
        r.fault = fault_seen;
        return r;
    endfunction

    function automatic stim_row_t scan_row(input int a, input int b, input int c, input int d,
                                           input int e, input logic known, input int cur,
                                           input logic trip, input logic fault);
        stim_row_t row;
        row            = '0;
        row.kind       = ROW_SCAN;
        row.smp[0]     = a[SMP_W-1:0];
        row.smp[1]     = b[SMP_W-1:0];
        row.smp[2]     = c[SMP_W-1:0];
        row.smp[3]     = d[SMP_W-1:0];
        row.smp[4]     = e[SMP_W-1:0];
        row.known      = known;
        row.want.cur   = cur[CUR_BITS-1:0];
        row.want.trip  = trip;
        row.want.fault = fault;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input logic sel, input int val);
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_CFG;
        row.reg_sel = sel;
        row.wval    = val[11:0];
        return row;
    endfunction

    // Scans follow a held level with small noise and occasional outliers, so the
    // filter settles and the persistence counter gets long runs on either side.
    function automatic logic [4:0][SMP_W-1:0] next_scan();
        logic [4:0][SMP_W-1:0] smp;
        bit                    wild;
        int                    v;
        if (run_left == 0)
        begin
            if ($urandom_range(3) == 0)
                level = $urandom_range(1) ? 4095 : 0;
            else
                level = $urandom_range(4095);
            run_left = $urandom_range(200, 20);
        end
        run_left--;
        wild = ($urandom_range(19) == 0);
        for (int i = 0; i < N_SAMPLES; i++)
        begin
            if (wild || $urandom_range(9) == 0)
                v = $urandom_range(4095);
            else
                v = level + $urandom_range(128) - 64;
            if (v < 0)
                v = 0;
            if (v > 4095)
                v = 4095;
            smp[i] = v[SMP_W-1:0];
        end
        return smp;
    endfunction

    // Called at a falling edge; returns at a falling edge with s_tvalid still high,
    // so the next caller either presents a new word or lowers it.
    task automatic send_scan(input logic [4:0][SMP_W-1:0] smp, input logic known,
                             input reading_t typed);
        reading_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, smp};
        do @(posedge clk); while (!s_tready);
        r = predict_reading(smp);
        readings_due.push_back(known ? typed : r);
        scans_in++;
        @(negedge clk);
    endtask

    task automatic idle_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (readings_due.size() != 0)
            @(negedge clk);
    endtask

    // Write then read back; bits above the field carry random junk that must be dropped.
    task automatic write_reg(input logic sel, input logic [11:0] val);
        logic [APB_DW-1:0] word;
        word = $urandom;
        if (sel == REG_MAX_CURRENT)
            word[11:0] = val;
        else
            word[LIMIT_BITS-1:0] = val[LIMIT_BITS-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_MAX_CURRENT)
            lim_ma = int'($signed(val));
        else
            persist_lim = int'(val[LIMIT_BITS-1:0]);
        cfg_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_MAX_CURRENT)
        begin
            if (prdata[11:0] != val)
                report_mismatch("max_current_ma readback", int'(prdata[11:0]), int'(val));
        end
        else if (prdata[LIMIT_BITS-1:0] != val[LIMIT_BITS-1:0])
            report_mismatch("persist_limit readback", int'(prdata[LIMIT_BITS-1:0]),
                            int'(val[LIMIT_BITS-1:0]));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Output side: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (m_tvalid && m_tready)
        begin
            if (readings_due.size() == 0)
                report_mismatch("word with nothing expected", int'(m_tdata[11:0]), 0);
            else
            begin
                want = readings_due.pop_front();
                if (m_tdata[11:0] != want.cur)
                    report_mismatch("current_ma", int'($signed(m_tdata[11:0])),
                                    int'($signed(want.cur)));
                if (m_tuser[0] != want.trip)
                    report_mismatch("trip_pulse", int'(m_tuser[0]), int'(want.trip));
                if (m_tuser[1] != want.fault)
                    report_mismatch("fault_latched", int'(m_tuser[1]), int'(want.fault));
            end
            if (m_tuser[0])
                trips_seen++;
            scans_out++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, readings_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t directed_rows[$];
        int        seg_lim;
        int        seg_persist;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        acc_q         = 0;
        acc_primed    = 1'b0;
        over_cnt      = 0;
        fault_seen    = 1'b0;
        lim_ma        = 1500;
        persist_lim   = 50;
        fail_count    = 0;
        scans_in      = 0;
        scans_out     = 0;
        trips_seen    = 0;
        cfg_writes    = 0;
        hold_cycles   = 0;
        quiet_cycles  = 0;
        level         = 0;
        run_left      = 0;
        send_idle_pct = 15;
        recv_idle_pct = 65;

        // All-4095 scans sit at full scale, 1870 mA, and the filter does not move.
        // The first scan loads the filter directly; trimmed outliers change nothing.
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 0));
        directed_rows.push_back(scan_row(0, 4095, 4095, 4095, 4095, 1, 1870, 0, 0));
        directed_rows.push_back(scan_row(4095, 4095, 0, 4095, 4095, 1, 1870, 0, 0));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 0, 1, 1870, 0, 0));
        // Count is four; lowering the limit to two makes the next scan trip.
        directed_rows.push_back(cfg_row(REG_PERSIST, 2));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 1, 1));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 1));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 1));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 1, 1));
        // Equal to the limit is not over it; one below is.
        directed_rows.push_back(cfg_row(REG_MAX_CURRENT, 1870));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 1));
        directed_rows.push_back(cfg_row(REG_MAX_CURRENT, 1869));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 1));
        directed_rows.push_back(cfg_row(REG_MAX_CURRENT, 2047));
        directed_rows.push_back(scan_row(4095, 4095, 4095, 4095, 4095, 1, 1870, 0, 1));
        directed_rows.push_back(cfg_row(REG_MAX_CURRENT, -200));
        directed_rows.push_back(cfg_row(REG_PERSIST, 0));
        directed_rows.push_back(scan_row(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed_rows.push_back(scan_row(0, 4095, 2048, 1, 4094, 0, 0, 0, 0));
        directed_rows.push_back(scan_row(4095, 0, 4095, 0, 2730, 0, 0, 0, 0));
        directed_rows.push_back(scan_row(1365, 2730, 1365, 2730, 4095, 0, 0, 0, 0));
        directed_rows.push_back(cfg_row(REG_PERSIST, 1023));
        directed_rows.push_back(scan_row(0, 0, 0, 4095, 4095, 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
            begin
                idle_until_drained();
                write_reg(directed_rows[i].reg_sel, directed_rows[i].wval);
            end
            else
                send_scan(directed_rows[i].smp, directed_rows[i].known, directed_rows[i].want);
        end

        for (int seg = 0; seg < N_SEGS; seg++)
        begin
            send_idle_pct = (seg < 2) ? 15 : ((seg < 4) ? 65 : 0);
            recv_idle_pct = (seg < 2) ? 65 : ((seg < 4) ? 15 : 0);
            case (seg)
                0: begin seg_lim = -200; seg_persist = 0;    end
                1: begin seg_lim = 2047; seg_persist = 1023; end
                2: begin seg_lim = 1000; seg_persist = 8;    end
                3: begin seg_lim = 1200; seg_persist = 3;    end
                default:
                begin
                    seg_lim     = $urandom_range(2247) - 200;
                    seg_persist = $urandom_range(30);
                end
            endcase
            idle_until_drained();
            write_reg(REG_MAX_CURRENT, 12'(seg_lim));
            write_reg(REG_PERSIST, 12'(seg_persist));
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Output held off while input keeps coming, so the core backs up.
                if (seg == 4 && n == 100)
                    hold_cycles = HOLD_OFF;
                send_scan(next_scan(), 1'b0, '0);
            end
        end

        idle_until_drained();
        repeat (SETTLE) @(posedge clk);

        $display("Run covered %0d scans, %0d trips and %0d register writes,", scans_in,
                 trips_seen, cfg_writes);
        $display("under three idle patterns and one long output hold-off.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
